### rtl/dws_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the diagonal wipe sequencer.
// No dependencies; the front end, back end and top level refer to names here by dws_pkg:: scope.
package dws_pkg;

  // Default coordinate width of the pixel map
  localparam int COORD_BITS_DEF = 10;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Fixed field widths
  localparam int HOLD_W  = 16;
  localparam int INDEX_W = 8;
  localparam int CORNER_W = 2;

  // Register reset values
  localparam logic [HOLD_W-1:0]  HOLD_FRAMES_RST = 16'd20;
  localparam logic [INDEX_W-1:0] INDEX_STEP_RST  = 8'd16;

  // Output bus: palette index, then swept flag, padded to whole bytes
  localparam int OUT_DATA_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EXTENT_X    = 2'd0,
    REG_EXTENT_Y    = 2'd1,
    REG_HOLD_FRAMES = 2'd2,
    REG_INDEX_STEP  = 2'd3
  } cfg_reg_t;

  // Item kinds carried on tuser
  localparam logic ACTION_QUERY = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  // Start corners
  typedef enum logic [CORNER_W-1:0] {
    CORNER_BOTTOM_LEFT  = 2'd0,
    CORNER_TOP_RIGHT    = 2'd1,
    CORNER_BOTTOM_RIGHT = 2'd2,
    CORNER_TOP_LEFT     = 2'd3
  } corner_t;

endpackage

### rtl/dws_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, wipe sequencing state and item classification.
// Depends on dws_pkg. Feeds query entries to the queue; ticks are consumed here.
module dws_front #(
  parameter int COORD_BITS = dws_pkg::COORD_BITS_DEF,
  parameter int IN_DATA_W  = 24,
  parameter int ENTRY_W    = 3 * COORD_BITS + 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dws_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [dws_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_DATA_W-1:0]            in_tdata,
  input  logic                            in_tuser,
  output logic                            push_valid,
  output logic [ENTRY_W-1:0]              push_data,
  input  logic                            q_full,
  output logic [COORD_BITS-1:0]           extent_x,
  output logic [COORD_BITS-1:0]           extent_y
);

  localparam int LEVEL_W = COORD_BITS + 2;

  // Configuration registers
  logic [COORD_BITS-1:0]           ext_x_r, ext_y_r;
  logic [dws_pkg::HOLD_W-1:0]      hold_frames_r;
  logic [dws_pkg::INDEX_W-1:0]     step_r;

  // Wipe state
  logic                            running_r, running_nxt;
  logic [LEVEL_W-1:0]              level_r, level_nxt, eff_level;
  logic [LEVEL_W-1:0]              limit_r, limit_nxt, eff_limit, new_limit;
  logic [dws_pkg::HOLD_W-1:0]      hold_r, hold_nxt, eff_hold;
  logic [dws_pkg::CORNER_W-1:0]    corner_r, corner_nxt, eff_corner;
  logic [dws_pkg::INDEX_W-1:0]     from_r, from_nxt, eff_from;
  logic [dws_pkg::INDEX_W-1:0]     to_r, to_nxt, eff_to;

  logic                            accept;
  logic [COORD_BITS-1:0]           in_x, in_y;
  logic [dws_pkg::CORNER_W-1:0]    in_corner;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign in_x      = in_tdata[COORD_BITS-1:0];
  assign in_y      = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_corner = in_tdata[2*COORD_BITS+dws_pkg::CORNER_W-1:2*COORD_BITS];
  assign new_limit = {2'b00, ext_x_r} + {2'b00, ext_y_r};
  assign extent_x  = ext_x_r;
  assign extent_y  = ext_y_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_x_r       <= '0;
      ext_y_r       <= '0;
      hold_frames_r <= dws_pkg::HOLD_FRAMES_RST;
      step_r        <= dws_pkg::INDEX_STEP_RST;
    end else if (cfg_we) begin
      case (dws_pkg::cfg_reg_t'(cfg_addr))
        dws_pkg::REG_EXTENT_X:    ext_x_r       <= cfg_data[COORD_BITS-1:0];
        dws_pkg::REG_EXTENT_Y:    ext_y_r       <= cfg_data[COORD_BITS-1:0];
        dws_pkg::REG_HOLD_FRAMES: hold_frames_r <= cfg_data[dws_pkg::HOLD_W-1:0];
        dws_pkg::REG_INDEX_STEP:  step_r        <= cfg_data[dws_pkg::INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // Start the first wipe on the first item, whatever its kind
  always_comb begin
    eff_level  = level_r;
    eff_limit  = limit_r;
    eff_hold   = hold_r;
    eff_corner = corner_r;
    eff_from   = from_r;
    eff_to     = to_r;
    if (!running_r) begin
      eff_level  = '0;
      eff_limit  = new_limit;
      eff_hold   = '0;
      eff_corner = in_corner;
      eff_from   = to_r;
      eff_to     = to_r + step_r;
    end
  end

  // Advance sweep, count hold frames, or start the next wipe on a tick
  always_comb begin
    running_nxt = running_r;
    level_nxt   = level_r;
    limit_nxt   = limit_r;
    hold_nxt    = hold_r;
    corner_nxt  = corner_r;
    from_nxt    = from_r;
    to_nxt      = to_r;
    if (accept) begin
      running_nxt = 1'b1;
      level_nxt   = eff_level;
      limit_nxt   = eff_limit;
      hold_nxt    = eff_hold;
      corner_nxt  = eff_corner;
      from_nxt    = eff_from;
      to_nxt      = eff_to;
      if (in_tuser == dws_pkg::ACTION_TICK) begin
        if (eff_level < eff_limit) begin
          level_nxt = eff_level + 1'b1;
        end else if (eff_hold < hold_frames_r) begin
          hold_nxt = eff_hold + 1'b1;
        end else begin
          level_nxt  = '0;
          limit_nxt  = new_limit;
          hold_nxt   = '0;
          corner_nxt = in_corner;
          from_nxt   = eff_to;
          to_nxt     = eff_to + step_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      level_r   <= '0;
      limit_r   <= '0;
      hold_r    <= '0;
      corner_r  <= '0;
      from_r    <= '0;
      to_r      <= '0;
    end else begin
      running_r <= running_nxt;
      level_r   <= level_nxt;
      limit_r   <= limit_nxt;
      hold_r    <= hold_nxt;
      corner_r  <= corner_nxt;
      from_r    <= from_nxt;
      to_r      <= to_nxt;
    end
  end

  // Queue a query with the wipe state it sees
  assign push_valid = accept && (in_tuser == dws_pkg::ACTION_QUERY);
  assign push_data  = {eff_to, eff_from, eff_level, eff_corner, in_y, in_x};

  // Checks
  a_level_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= limit_r)
    else $error("sweep level passed the sweep limit");

  a_running_stays: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |=> running_r)
    else $error("running flag dropped without reset");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push_valid)
    else $error("query pushed into a full queue");

endmodule

### rtl/dws_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front end and the back end.
// Depends on nothing but its width parameter.
module dws_queue #(
  parameter int ENTRY_W = 50
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  logic [ENTRY_W-1:0] push_data,
  output logic               full,
  output logic               pop_valid,
  input  logic               pop_ready,
  output logic [ENTRY_W-1:0] pop_data
);

  logic [ENTRY_W-1:0] slot_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign do_pop    = pop_valid && pop_ready;
  assign pop_data  = slot_r[rd_ptr_r];

  // Store a pushed entry
  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_valid;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, push_valid} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue occupancy out of range");

  a_ptrs_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with occupancy");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !do_pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("queue occupancy failed to rise on push");

endmodule

### rtl/dws_back.sv
`timescale 1ns / 1ps
// Back end: diagonal distance, sweep compare and the registered result stage.
// Depends on dws_pkg; takes query entries from the queue.
module dws_back #(
  parameter int COORD_BITS = dws_pkg::COORD_BITS_DEF,
  parameter int ENTRY_W    = 3 * COORD_BITS + 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [COORD_BITS-1:0]             extent_x,
  input  logic [COORD_BITS-1:0]             extent_y,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  logic [ENTRY_W-1:0]                q_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dws_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int LEVEL_W = COORD_BITS + 2;
  localparam int DIST_W  = COORD_BITS + 3;

  logic [COORD_BITS-1:0]          e_x, e_y;
  logic [dws_pkg::CORNER_W-1:0]   e_corner;
  logic [LEVEL_W-1:0]             e_level;
  logic [dws_pkg::INDEX_W-1:0]    e_from, e_to;

  logic signed [DIST_W-1:0]       px, py, ew, eh, term_x, term_y, diag_sum, lvl;
  logic                           in_sweep;
  logic                           take;

  logic                           valid_r, valid_nxt;
  logic [dws_pkg::INDEX_W-1:0]    index_r;
  logic                           swept_r;

  assign {e_to, e_from, e_level, e_corner, e_y, e_x} = q_data;

  // Signed diagonal distance from the start corner
  always_comb begin
    px = signed'({3'b000, e_x});
    py = signed'({3'b000, e_y});
    ew = signed'({3'b000, extent_x});
    eh = signed'({3'b000, extent_y});
    case (dws_pkg::corner_t'(e_corner))
      dws_pkg::CORNER_BOTTOM_LEFT: begin
        term_x = px;
        term_y = py;
      end
      dws_pkg::CORNER_TOP_RIGHT: begin
        term_x = ew - px;
        term_y = eh - py;
      end
      dws_pkg::CORNER_BOTTOM_RIGHT: begin
        term_x = ew - px;
        term_y = py;
      end
      default: begin
        term_x = px;
        term_y = eh - py;
      end
    endcase
    diag_sum = term_x + term_y;
    lvl      = signed'({1'b0, e_level});
    in_sweep = (diag_sum <= lvl);
  end

  // Take a new entry whenever the result register is free or being drained
  assign q_ready = !valid_r || out_tready;
  assign take    = q_valid && q_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the result payload until transferred
  always_ff @(posedge clk) begin
    if (take) begin
      index_r <= in_sweep ? e_to : e_from;
      swept_r <= in_sweep;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(dws_pkg::OUT_DATA_W - dws_pkg::INDEX_W - 1){1'b0}}, swept_r, index_r};

  // Checks
  a_stall_holds_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |=> (valid_r && $stable(index_r) && $stable(swept_r)))
    else $error("result changed while stalled");

  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |-> !take)
    else $error("entry taken over a pending result");

  a_take_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> valid_r)
    else $error("taken entry produced no result");

endmodule

### rtl/diagonal_wipe_sequencer_core.sv
`timescale 1ns / 1ps
// Diagonal wipe sequencer, top level.
// Depends on dws_pkg, dws_front, dws_queue and dws_back.
//
// Usage:
//   Input stream (in_*): one item per transfer. in_tuser selects a pixel query
//   or an end-of-frame tick; in_tdata carries the pixel coordinates and the
//   corner to use should a new wipe start with this item.
//   Result stream (out_*): one result per pixel query, none per tick, in order.
//   Configuration (cfg_*): write extents, hold length and index step while idle.
// Timing:
//   A query accepted on the input is written into the queue, then taken into the
//   result register of the back end, which drives out_tvalid. One item per cycle
//   is sustained while out_tready stays high; the front end registers the wipe
//   state update and the back end registers the result of the distance compare.
//   Ticks leave no trace on the result stream.
// Reset (rst_n low, synchronous) clears the wipe state, empties the queue and
// restores the register defaults. When the receiver stalls, the result is held,
// queries collect in the two-entry queue, and in_tready drops once it is full.
module diagonal_wipe_sequencer_core #(
  parameter int COORD_BITS = dws_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [dws_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dws_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: pixel_x, pixel_y, corner_pick, zero padding
  input  logic [((2*COORD_BITS+2+7)/8)*8-1:0] in_tdata,
  // tuser: action
  input  logic                               in_tuser,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: palette_index[7:0], swept, zero padding
  output logic [dws_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int IN_DATA_W = ((2 * COORD_BITS + 2 + 7) / 8) * 8;
  localparam int ENTRY_W   = 3 * COORD_BITS + 20;

  logic                  push_valid;
  logic [ENTRY_W-1:0]    push_data;
  logic                  q_full;
  logic                  q_valid, q_ready;
  logic [ENTRY_W-1:0]    q_data;
  logic [COORD_BITS-1:0] extent_x, extent_y;

  dws_front #(
    .COORD_BITS (COORD_BITS),
    .IN_DATA_W  (IN_DATA_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full),
    .extent_x   (extent_x),
    .extent_y   (extent_y)
  );

  dws_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  dws_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .extent_x   (extent_x),
    .extent_y   (extent_y),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
